### design/mde_pkg.sv
`timescale 1ns / 1ps
package mde_pkg;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_FOCAL_X     = 3'd0,
    REG_FOCAL_Y     = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_MARKER_SIDE = 3'd4,
    REG_FALLBACK    = 3'd5
  } reg_idx_e;

  localparam logic [15:0] FOCAL_X_RST  = 16'd9600;
  localparam logic [15:0] FOCAL_Y_RST  = 16'd9600;
  localparam logic [15:0] CENTER_X_RST = 16'd5120;
  localparam logic [15:0] CENTER_Y_RST = 16'd3840;
  localparam logic [15:0] MARKER_RST   = 16'd1024;
  localparam logic [15:0] FALLBACK_RST = 16'd4096;

  // normalize divider: 18 quotient bits, one per stage
  localparam int NORM_STEPS = 18;
  localparam int NORM_LAT   = NORM_STEPS + 2;
  localparam logic [17:0] NORM_POS_MAX = 18'h1FFFF;
  localparam logic [17:0] NORM_NEG_MAX = 18'h20000;

  // square root: 19 result bits, one per stage
  localparam int SQRT_STEPS = 19;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;

  // depth divider: 16 quotient bits, one per stage
  localparam int DEPTH_STEPS = 16;
  localparam int DEPTH_LAT   = DEPTH_STEPS + 2;
  localparam logic [15:0] DEPTH_MIN = 16'd410;
  localparam logic [15:0] DEPTH_MAX = 16'd40960;

  // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT, exact for x < 2^23
  localparam logic [21:0] DIV3_MUL   = 22'd2796203;
  localparam int          DIV3_SHIFT = 23;

  // squares, side sum, divide-by-3 product
  localparam int PIPE_LAT = NORM_LAT + SQRT_LAT + DEPTH_LAT + 3;

endpackage

### design/marker_depth_estimator_core.sv
`timescale 1ns / 1ps
// Pipeline: 61 stages from the input transaction to the output register, most of them in the
// bit-per-stage normalize divider, square root and depth divider.
// Throughput: one corner set per cycle; a skid register behind the output keeps the
// pipeline moving under output stall until a second result is waiting, then it freezes.
// Reset: asynchronous, active low; clears valid bits and loads register defaults.
module marker_depth_estimator_core import mde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] corner_x0_i,
  input  logic [15:0] corner_y0_i,
  input  logic [15:0] corner_x1_i,
  input  logic [15:0] corner_y1_i,
  input  logic [15:0] corner_x2_i,
  input  logic [15:0] corner_y2_i,
  input  logic [15:0] corner_x3_i,
  input  logic [15:0] corner_y3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] depth_o,
  output logic        used_fallback_o
);

  localparam int SA [3] = '{0, 1, 3};
  localparam int SB [3] = '{1, 2, 0};

  logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q, side_q, fb_q;
  logic        wr_en;
  reg_idx_e    widx;

  logic        en;
  logic [PIPE_LAT-1:0] vld_q;

  logic [15:0]        px [4];
  logic [15:0]        py [4];
  logic signed [17:0] nx [4];
  logic signed [17:0] ny [4];
  logic [18:0]        root [3];
  logic [20:0]        sum_q;
  logic [42:0]        prod_q;
  logic [15:0]        pipe_depth;
  logic               pipe_fb;

  logic        out_valid_q, skid_valid_q;
  logic [15:0] out_depth_q, skid_depth_q;
  logic        out_fb_q, skid_fb_q;

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_X_RST;
      focal_y_q  <= FOCAL_Y_RST;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      side_q     <= MARKER_RST;
      fb_q       <= FALLBACK_RST;
    end else if (wr_en) begin
      case (widx)
        REG_FOCAL_X:     focal_x_q  <= pwdata[15:0];
        REG_FOCAL_Y:     focal_y_q  <= pwdata[15:0];
        REG_CENTER_X:    center_x_q <= pwdata[15:0];
        REG_CENTER_Y:    center_y_q <= pwdata[15:0];
        REG_MARKER_SIDE: side_q     <= pwdata[15:0];
        REG_FALLBACK:    fb_q       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_FOCAL_X:     prdata = {16'b0, focal_x_q};
      REG_FOCAL_Y:     prdata = {16'b0, focal_y_q};
      REG_CENTER_X:    prdata = {16'b0, center_x_q};
      REG_CENTER_Y:    prdata = {16'b0, center_y_q};
      REG_MARKER_SIDE: prdata = {16'b0, side_q};
      REG_FALLBACK:    prdata = {16'b0, fb_q};
      default:         prdata = '0;
    endcase
  end

  // pipeline advances unless the skid register is holding a result
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  assign px[0] = corner_x0_i;
  assign py[0] = corner_y0_i;
  assign px[1] = corner_x1_i;
  assign py[1] = corner_y1_i;
  assign px[2] = corner_x2_i;
  assign py[2] = corner_y2_i;
  assign px[3] = corner_x3_i;
  assign py[3] = corner_y3_i;

  for (genvar i = 0; i < 4; i++) begin : g_corner
    mde_norm u_norm_x (
      .clk_i (clk_i),
      .en_i  (en),
      .p_i   (px[i]),
      .c_i   (center_x_q),
      .f_i   (focal_x_q),
      .n_o   (nx[i])
    );
    mde_norm u_norm_y (
      .clk_i (clk_i),
      .en_i  (en),
      .p_i   (py[i]),
      .c_i   (center_y_q),
      .f_i   (focal_y_q),
      .n_o   (ny[i])
    );
  end

  for (genvar s = 0; s < 3; s++) begin : g_side
    logic signed [18:0] dx, dy;
    logic [17:0]        ax, ay;
    logic [35:0]        sqx_q, sqy_q;
    assign dx = 19'(nx[SB[s]]) - 19'(nx[SA[s]]);
    assign dy = 19'(ny[SB[s]]) - 19'(ny[SA[s]]);
    assign ax = dx[18] ? 18'(-dx) : dx[17:0];
    assign ay = dy[18] ? 18'(-dy) : dy[17:0];
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqx_q <= 36'(ax) * 36'(ax);
        sqy_q <= 36'(ay) * 36'(ay);
      end
    end
    mde_isqrt u_sqrt (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (37'(sqx_q) + 37'(sqy_q)),
      .r_o   (root[s])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q  <= 21'(root[0]) + 21'(root[1]) + 21'(root[2]);
      prod_q <= 43'(sum_q) * 43'(DIV3_MUL);
    end
  end

  mde_depth u_depth (
    .clk_i      (clk_i),
    .en_i       (en),
    .avg_i      (prod_q[DIV3_SHIFT+18:DIV3_SHIFT]),
    .side_i     (side_q),
    .fb_i       (fb_q),
    .depth_o    (pipe_depth),
    .fallback_o (pipe_fb)
  );

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (en && vld_q[PIPE_LAT-1]) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= vld_q[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (en) begin
        skid_depth_q <= pipe_depth;
        skid_fb_q    <= pipe_fb;
      end
    end else if (skid_valid_q) begin
      out_depth_q <= skid_depth_q;
      out_fb_q    <= skid_fb_q;
    end else begin
      out_depth_q <= pipe_depth;
      out_fb_q    <= pipe_fb;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign depth_o         = out_depth_q;
  assign used_fallback_o = out_fb_q;

endmodule

### design/mde_norm.sv
`timescale 1ns / 1ps
module mde_norm import mde_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        p_i,
  input  logic [15:0]        c_i,
  input  logic [15:0]        f_i,
  output logic signed [17:0] n_o
);

  logic [16:0] d;
  logic [15:0] mag;
  logic [31:0] rem_q  [NORM_STEPS+1];
  logic [17:0] quo_q  [NORM_STEPS+1];
  logic        neg_q  [NORM_STEPS+1];
  logic        ovf_q  [NORM_STEPS+1];
  logic        zero_q [NORM_STEPS+1];
  logic [17:0] q_fin;
  logic [17:0] n_d, n_q;

  assign d   = {1'b0, p_i} - {1'b0, c_i};
  assign mag = d[16] ? 16'(-d) : d[15:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {mag, 16'b0};
      quo_q[0]  <= '0;
      neg_q[0]  <= d[16];
      // quotient would reach 2^18 (also covers zero focal length)
      ovf_q[0]  <= {2'b0, mag} >= {f_i, 2'b0};
      zero_q[0] <= (mag == 16'd0);
    end
  end

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_step
    localparam int K = NORM_STEPS - 1 - j;
    logic [33:0] dvs;
    logic [34:0] diff;
    assign dvs  = 34'(f_i) << K;
    assign diff = {3'b0, rem_q[j]} - {1'b0, dvs};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= diff[34] ? rem_q[j] : diff[31:0];
        quo_q[j+1]  <= {quo_q[j][NORM_STEPS-2:0], ~diff[34]};
        neg_q[j+1]  <= neg_q[j];
        ovf_q[j+1]  <= ovf_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  assign q_fin = quo_q[NORM_STEPS];

  always_comb begin
    if (zero_q[NORM_STEPS]) begin
      n_d = '0;
    end else if (neg_q[NORM_STEPS]) begin
      n_d = (ovf_q[NORM_STEPS] || q_fin > NORM_NEG_MAX) ? NORM_NEG_MAX : 18'(-q_fin);
    end else begin
      n_d = (ovf_q[NORM_STEPS] || q_fin > NORM_POS_MAX) ? NORM_POS_MAX : q_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
    end
  end

  assign n_o = signed'(n_q);

endmodule

### design/mde_isqrt.sv
`timescale 1ns / 1ps
module mde_isqrt import mde_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [36:0] v_i,
  output logic [18:0] r_o
);

  logic [36:0] rem_q [SQRT_STEPS+1];
  logic [18:0] res_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= v_i;
      res_q[0] <= '0;
    end
  end

  // (res + 2^k)^2 - res^2 = res*2^(k+1) + 2^(2k)
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam int K = SQRT_STEPS - 1 - j;
    logic [37:0] trial;
    logic [38:0] diff;
    assign trial = (38'(res_q[j]) << (K + 1)) + (38'd1 << (2 * K));
    assign diff  = {2'b0, rem_q[j]} - {1'b0, trial};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= diff[38] ? rem_q[j] : diff[36:0];
        res_q[j+1] <= diff[38] ? res_q[j] : (res_q[j] | (19'd1 << K));
      end
    end
  end

  assign r_o = res_q[SQRT_STEPS];

endmodule

### design/mde_depth.sv
`timescale 1ns / 1ps
module mde_depth import mde_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [18:0] avg_i,
  input  logic [15:0] side_i,
  input  logic [15:0] fb_i,
  output logic [15:0] depth_o,
  output logic        fallback_o
);

  logic [31:0] rem_q  [DEPTH_STEPS+1];
  logic [15:0] quo_q  [DEPTH_STEPS+1];
  logic [18:0] avg_q  [DEPTH_STEPS+1];
  logic [15:0] fb_q   [DEPTH_STEPS+1];
  logic        ovf_q  [DEPTH_STEPS+1];
  logic        zero_q [DEPTH_STEPS+1];
  logic [15:0] q_fin;
  logic [15:0] depth_d, depth_q;
  logic        fallback_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {side_i, 16'b0};
      quo_q[0]  <= '0;
      avg_q[0]  <= avg_i;
      fb_q[0]   <= fb_i;
      ovf_q[0]  <= {3'b0, side_i} >= avg_i;
      zero_q[0] <= (avg_i == 19'd0);
    end
  end

  for (genvar j = 0; j < DEPTH_STEPS; j++) begin : g_step
    localparam int K = DEPTH_STEPS - 1 - j;
    logic [34:0] dvs;
    logic [35:0] diff;
    assign dvs  = 35'(avg_q[j]) << K;
    assign diff = {4'b0, rem_q[j]} - {1'b0, dvs};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= diff[35] ? rem_q[j] : diff[31:0];
        quo_q[j+1]  <= {quo_q[j][DEPTH_STEPS-2:0], ~diff[35]};
        avg_q[j+1]  <= avg_q[j];
        fb_q[j+1]   <= fb_q[j];
        ovf_q[j+1]  <= ovf_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  assign q_fin = quo_q[DEPTH_STEPS];

  always_comb begin
    if (zero_q[DEPTH_STEPS]) begin
      depth_d = fb_q[DEPTH_STEPS];
    end else if (ovf_q[DEPTH_STEPS] || q_fin > DEPTH_MAX) begin
      depth_d = DEPTH_MAX;
    end else if (q_fin < DEPTH_MIN) begin
      depth_d = DEPTH_MIN;
    end else begin
      depth_d = q_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      depth_q    <= depth_d;
      fallback_q <= zero_q[DEPTH_STEPS];
    end
  end

  assign depth_o    = depth_q;
  assign fallback_o = fallback_q;

endmodule

### dv/tb_marker_depth_estimator_core.sv
`timescale 1ns / 1ps
module tb_marker_depth_estimator_core import mde_pkg::*;;

  typedef struct {
    logic [15:0] c [8];   // x0 y0 x1 y1 x2 y2 x3 y3
    bit          known;
    logic [15:0] dep;
    bit          fb;
  } row_t;

  typedef struct {
    logic [15:0] dep;
    bit          fb;
  } depth_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] cx0 = '0, cy0 = '0, cx1 = '0, cy1 = '0;
  logic [15:0] cx2 = '0, cy2 = '0, cx3 = '0, cy3 = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] depth_o;
  logic        used_fallback_o;

  marker_depth_estimator_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .corner_x0_i(cx0), .corner_y0_i(cy0), .corner_x1_i(cx1), .corner_y1_i(cy1),
    .corner_x2_i(cx2), .corner_y2_i(cy2), .corner_x3_i(cx3), .corner_y3_i(cy3),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .depth_o(depth_o), .used_fallback_o(used_fallback_o)
  );

  // shadow copy of the camera registers
  logic [15:0] m_fx, m_fy, m_cx, m_cy, m_side, m_fallback;

  depth_res_t depth_q [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint norm_coord(logic [15:0] p, logic [15:0] c, logic [15:0] f);
    longint d;
    longint unsigned mag, q;
    d = longint'(p) - longint'(c);
    mag = (d < 0) ? -d : d;
    if (d == 0) return 0;
    if (f == 0) q = 131072;
    else q = (mag << 16) / f;
    if (d < 0) return (q > 131072) ? -131072 : -longint'(q);
    return (q > 131071) ? 131071 : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned side_length(longint ax, longint ay, longint bx,
                                                  longint by);
    longint dx, dy;
    dx = bx - ax;
    dy = by - ay;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return int_sqrt(dx * dx + dy * dy);
  endfunction

  function automatic depth_res_t predict_depth(logic [15:0] c [8]);
    longint nx [4], ny [4];
    longint unsigned avg, d;
    depth_res_t r;
    for (int i = 0; i < 4; i++) begin
      nx[i] = norm_coord(c[2*i], m_cx, m_fx);
      ny[i] = norm_coord(c[2*i+1], m_cy, m_fy);
    end
    avg = (side_length(nx[0], ny[0], nx[1], ny[1]) + side_length(nx[1], ny[1], nx[2], ny[2])
          + side_length(nx[3], ny[3], nx[0], ny[0])) / 3;
    if (avg == 0) begin
      r.dep = m_fallback;
      r.fb = 1'b1;
      return r;
    end
    d = (longint'(m_side) << 16) / avg;
    if (d < 410) d = 410;
    if (d > 40960) d = 40960;
    r.dep = d[15:0];
    r.fb = 1'b0;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_FOCAL_X:     m_fx = val;
      REG_FOCAL_Y:     m_fy = val;
      REG_CENTER_X:    m_cx = val;
      REG_CENTER_Y:    m_cy = val;
      REG_MARKER_SIDE: m_side = val;
      REG_FALLBACK:    m_fallback = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_camera(logic [15:0] fx, logic [15:0] fy, logic [15:0] ccx,
                            logic [15:0] ccy, logic [15:0] side, logic [15:0] fbd);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, ccx);
    write_reg(REG_CENTER_Y, ccy);
    write_reg(REG_MARKER_SIDE, side);
    write_reg(REG_FALLBACK, fbd);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_corners(logic [15:0] c [8], bit known, depth_res_t typed);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cx0 <= c[0]; cy0 <= c[1]; cx1 <= c[2]; cy1 <= c[3];
    cx2 <= c[4]; cy2 <= c[5]; cx3 <= c[6]; cy3 <= c[7];
    do @(posedge clk_i); while (in_stall_o);
    depth_q.push_back(known ? typed : predict_depth(c));
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] jitter(logic [15:0] base, int r);
    int v;
    v = int'(base) + $urandom_range(2*r) - r;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic random_corners(int n);
    logic [15:0] c [8];
    depth_res_t none;
    logic [15:0] bx, by;
    int r, mode;
    none = '{dep: '0, fb: 1'b0};
    repeat (n) begin
      mode = $urandom_range(9);
      bx = 16'($urandom); by = 16'($urandom);
      case ($urandom_range(2))
        0: r = $urandom_range(3);
        1: r = $urandom_range(64);
        default: r = $urandom_range(4000);
      endcase
      for (int i = 0; i < 4; i++) begin
        if (mode <= 6) begin
          // marker-like quad around a random point
          c[2*i] = jitter(bx, r); c[2*i+1] = jitter(by, r);
        end else if (mode <= 8) begin
          c[2*i] = 16'($urandom); c[2*i+1] = 16'($urandom);
        end else begin
          c[2*i] = bx; c[2*i+1] = by;   // collapsed marker
        end
      end
      send_corners(c, 1'b0, none);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic drain;
    while (depth_q.size() != 0) @(negedge clk_i);
    repeat (70) @(negedge clk_i);
  endtask

  // receiver: random stall, plus one long hold-off per token bump
  initial begin
    int seen, hold_left;
    seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_token != seen) begin
        seen = hold_token;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    depth_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (depth_q.size() == 0) begin
        $error("result transaction with nothing expected: depth %0d", depth_o);
        errors++;
      end else begin
        e = depth_q.pop_front();
        if (depth_o !== e.dep) begin
          $error("depth: expected %0d, actual %0d", e.dep, depth_o);
          errors++;
        end
        if (used_fallback_o !== e.fb) begin
          $error("used_fallback: expected %0d, actual %0d", e.fb, used_fallback_o);
          errors++;
        end
      end
    end
  end

  row_t directed [] = '{
    '{'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, 16'd4096, 1'b1},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      1'b1, 16'd4096, 1'b1},
    '{'{16'd5120, 16'd3840, 16'd5120, 16'd3840, 16'd5120, 16'd3840, 16'd5120, 16'd3840},
      1'b1, 16'd4096, 1'b1},
    // one LSB of spread: depth pinned at the upper clamp
    '{'{16'd5120, 16'd3840, 16'd5121, 16'd3840, 16'd5120, 16'd3840, 16'd5120, 16'd3840},
      1'b1, 16'd40960, 1'b0},
    '{'{16'h0, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF}, 1'b0, '0, 1'b0},
    '{'{16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 16'h0}, 1'b0, '0, 1'b0},
    '{'{16'h4000, 16'h3000, 16'h5000, 16'h3000, 16'h5000, 16'h4000, 16'h4000, 16'h4000},
      1'b0, '0, 1'b0},
    // only side 1-2 nonzero, then only side 3-0
    '{'{16'd100, 16'd100, 16'd100, 16'd100, 16'd9000, 16'd7000, 16'd100, 16'd100},
      1'b0, '0, 1'b0},
    '{'{16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'hAAAA, 16'h5555},
      1'b0, '0, 1'b0},
    '{'{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h1234, 16'hFEDC, 16'h8000, 16'h7FFF},
      1'b0, '0, 1'b0},
    '{'{16'd5100, 16'd3820, 16'd5140, 16'd3820, 16'd5140, 16'd3860, 16'd5100, 16'd3860},
      1'b0, '0, 1'b0}
  };

  initial begin
    depth_res_t typed;
    m_fx = FOCAL_X_RST; m_fy = FOCAL_Y_RST;
    m_cx = CENTER_X_RST; m_cy = CENTER_Y_RST;
    m_side = MARKER_RST; m_fallback = FALLBACK_RST;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values, no idling
    foreach (directed[i]) begin
      typed = '{dep: directed[i].dep, fb: directed[i].fb};
      send_corners(directed[i].c, directed[i].known, typed);
    end
    in_valid_i <= 1'b0;
    random_corners(270);
    drain();

    // small focal length, zero center and zero marker side; sparse sender
    set_camera(16'd16, 16'd16, 16'd0, 16'd0, 16'd0, 16'd410);
    idle_pct = 86;
    random_corners(280);
    drain();

    // largest values; stalling receiver
    set_camera(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd40960);
    idle_pct = 0; stall_pct = 86;
    random_corners(280);
    drain();

    // zero focal length saturates; long receiver hold-off with a busy sender
    set_camera(16'd0, 16'd0, 16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
               16'($urandom_range(410, 40960)));
    stall_pct = 0;
    hold_token++;
    random_corners(120);
    idle_pct = 37; stall_pct = 37;
    random_corners(160);
    drain();

    // unmapped indexes must leave the map untouched; set_camera then rewrites every register
    write_reg(3'd6, 16'h1234);
    write_reg(3'd7, 16'h4321);
    set_camera(16'($urandom_range(16, 65535)), 16'($urandom_range(16, 65535)),
               16'($urandom), 16'($urandom), 16'd1, 16'($urandom_range(410, 40960)));
    random_corners(140);
    idle_pct = 0; stall_pct = 0;
    random_corners(140);

    while (depth_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0 && depth_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
